/* hw/rtl/ipsd_pkg.sv */
// ----------------------------------------------------------------------------
// ipsd_pkg
// Shared types and constants of the IR pulse/space decoder.
// ----------------------------------------------------------------------------
package ipsd_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W        = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_UNIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PKT_LEN = 1'b1;
  localparam int unsigned CFG_DATA_W       = 8;

  localparam logic [7:0] TIME_UNIT_RST   = 8'd50;
  localparam logic [6:0] MAX_PKT_LEN_RST = 7'd4;

  localparam int unsigned DURATION_BITS_DEF = 24;
  localparam int unsigned HEADER_BYTES_DEF  = 2;
  localparam int unsigned HDR_CNT_W         = 2;

  localparam int unsigned OUT_DUR_W = 24;
  localparam int unsigned SMP_DUR_W = 15;   // 7-bit count times 8-bit unit

  // length byte carries the packet length offset by this value
  localparam logic [7:0] LEN_OFFSET = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       transfer_start;
  } in_t;

  typedef struct packed {
    logic [OUT_DUR_W-1:0] duration;
    logic                 is_pulse;
  } out_t;

  // decoded sample from the framer
  typedef struct packed {
    logic                 valid;
    logic                 pulse;
    logic [SMP_DUR_W-1:0] dur;
  } sample_t;

endpackage

/* hw/rtl/ir_pulse_space_decoder_top.sv */
// ----------------------------------------------------------------------------
// ir_pulse_space_decoder_top
// IR receiver byte stream to pulse/space run decoder.
// ----------------------------------------------------------------------------
// Takes one receiver byte per cycle; the byte is registered, then framed,
// scaled by the time unit, merged into the open run and, on a level change,
// written to the output register. Input stalls only when the registered
// byte closes a run while the output register is full and stalled; bytes
// that finish no run keep flowing. Configuration writes are taken any time
// but are meant for idle periods.
module ir_pulse_space_decoder_top #(
  parameter int unsigned DURATION_BITS = ipsd_pkg::DURATION_BITS_DEF,
  parameter int unsigned HEADER_BYTES  = ipsd_pkg::HEADER_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ipsd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ipsd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ipsd_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ipsd_pkg::out_t                    out_data_o
);

  logic [7:0]        time_unit_q;
  logic [6:0]        max_pkt_len_q;
  logic              s1_valid, s1_take, acc_ready;
  ipsd_pkg::in_t     s1_data;
  ipsd_pkg::sample_t sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_unit_q   <= ipsd_pkg::TIME_UNIT_RST;
      max_pkt_len_q <= ipsd_pkg::MAX_PKT_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipsd_pkg::CFG_TIME_UNIT:   time_unit_q   <= cfg_wdata_i[7:0];
        ipsd_pkg::CFG_MAX_PKT_LEN: max_pkt_len_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  assign s1_take = s1_valid && (!sample.valid || acc_ready);

  ipsd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .take_i    (s1_take),
    .valid_o   (s1_valid),
    .data_o    (s1_data)
  );

  ipsd_framer #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid),
    .data_i       (s1_data),
    .take_i       (s1_take),
    .time_unit_i  (time_unit_q),
    .max_pkt_len_i(max_pkt_len_q),
    .sample_o     (sample)
  );

  ipsd_run_acc #(
    .DURATION_BITS(DURATION_BITS)
  ) u_run_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample),
    .ready_o    (acc_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* hw/rtl/ipsd_in_reg.sv */
// ----------------------------------------------------------------------------
// ipsd_in_reg
// Input register stage; holds one byte until the decoder consumes it.
// ----------------------------------------------------------------------------
module ipsd_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ipsd_pkg::in_t in_data_i,
  input  logic          take_i,
  output logic          valid_o,
  output ipsd_pkg::in_t data_o
);

  logic          valid_q, valid_d;
  ipsd_pkg::in_t data_q;
  logic          accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hw/rtl/ipsd_framer.sv */
// ----------------------------------------------------------------------------
// ipsd_framer
// Transfer/packet framing: skips header bytes, tracks packet length and
// discard, and turns sample bytes into scaled samples.
// ----------------------------------------------------------------------------
module ipsd_framer #(
  parameter int unsigned HEADER_BYTES = ipsd_pkg::HEADER_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ipsd_pkg::in_t       data_i,
  input  logic                take_i,
  input  logic [7:0]          time_unit_i,
  input  logic [6:0]          max_pkt_len_i,
  output ipsd_pkg::sample_t   sample_o
);

  localparam logic [ipsd_pkg::HDR_CNT_W-1:0] HdrInit =
    ipsd_pkg::HDR_CNT_W'(HEADER_BYTES);
  localparam logic [ipsd_pkg::HDR_CNT_W-1:0] HdrOne = ipsd_pkg::HDR_CNT_W'(1);

  logic [ipsd_pkg::HDR_CNT_W-1:0] hdr_left_q, hdr_left_d, hdr_cur;
  logic [6:0]                     pkt_left_q, pkt_left_d;
  logic                           discard_q, discard_d, discard_cur;
  logic [7:0]                     len;

  assign len = data_i.data_byte ^ ipsd_pkg::LEN_OFFSET;

  always_comb begin
    hdr_cur     = data_i.transfer_start ? HdrInit : hdr_left_q;
    discard_cur = data_i.transfer_start ? 1'b0 : discard_q;
    hdr_left_d  = hdr_cur;
    discard_d   = discard_cur;
    pkt_left_d  = pkt_left_q;
    sample_o.valid = 1'b0;
    sample_o.pulse = data_i.data_byte[7];
    sample_o.dur   = ipsd_pkg::SMP_DUR_W'(data_i.data_byte[6:0] * time_unit_i);
    if (hdr_cur != '0) begin
      hdr_left_d = hdr_cur - HdrOne;
    end else if (discard_cur) begin
      // rest of the transfer dropped
    end else if (pkt_left_q == '0) begin
      if (len > {1'b0, max_pkt_len_i}) begin
        discard_d = 1'b1;
      end else begin
        pkt_left_d = len[6:0];
      end
    end else begin
      pkt_left_d     = pkt_left_q - 7'd1;
      sample_o.valid = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_left_q <= '0;
      pkt_left_q <= '0;
      discard_q  <= 1'b0;
    end else if (take_i) begin
      hdr_left_q <= hdr_left_d;
      pkt_left_q <= pkt_left_d;
      discard_q  <= discard_d;
    end
  end

endmodule

/* hw/rtl/ipsd_run_acc.sv */
// ----------------------------------------------------------------------------
// ipsd_run_acc
// Pulse/space run accumulator with saturating totals and the result register.
// ----------------------------------------------------------------------------
module ipsd_run_acc #(
  parameter int unsigned DURATION_BITS = ipsd_pkg::DURATION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipsd_pkg::sample_t sample_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ipsd_pkg::out_t    out_data_o
);

  localparam int unsigned DW = DURATION_BITS;

  logic [DW-1:0]  pulse_total_q, pulse_total_d;
  logic [DW-1:0]  space_total_q, space_total_d;
  logic           pulse_open_q, pulse_open_d;
  logic           out_valid_q, out_valid_d;
  ipsd_pkg::out_t out_data_q, out_data_d;

  logic          emit, out_free, fire;
  logic [DW-1:0] acc_base, acc_sat;
  logic [DW:0]   acc_sum;
  logic [DW+ipsd_pkg::OUT_DUR_W-1:0] emit_ext;
  logic [DW-1:0] emit_total;

  assign emit     = sample_i.pulse ? (space_total_q != '0) : pulse_open_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign ready_o  = !emit || out_free;
  assign fire     = sample_i.valid && ready_o;

  // one shared saturating adder for whichever level the sample carries
  always_comb begin
    if (sample_i.pulse) begin
      acc_base = (emit || !pulse_open_q) ? '0 : pulse_total_q;
    end else begin
      acc_base = space_total_q;
    end
    acc_sum = {1'b0, acc_base} + (DW+1)'(sample_i.dur);
    acc_sat = acc_sum[DW] ? '1 : acc_sum[DW-1:0];
  end

  assign emit_total = sample_i.pulse ? space_total_q : pulse_total_q;
  assign emit_ext   = {{ipsd_pkg::OUT_DUR_W{1'b0}}, emit_total};

  always_comb begin
    pulse_total_d = pulse_total_q;
    space_total_d = space_total_q;
    pulse_open_d  = pulse_open_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_data_d    = out_data_q;
    if (fire) begin
      if (sample_i.pulse) begin
        pulse_total_d = acc_sat;
        space_total_d = '0;
        pulse_open_d  = 1'b1;
      end else begin
        pulse_total_d = '0;
        pulse_open_d  = 1'b0;
        space_total_d = acc_sat;
      end
      if (emit) begin
        out_valid_d         = 1'b1;
        out_data_d.duration = emit_ext[ipsd_pkg::OUT_DUR_W-1:0];
        out_data_d.is_pulse = !sample_i.pulse;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_total_q <= '0;
      space_total_q <= '1;
      pulse_open_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      pulse_total_q <= pulse_total_d;
      space_total_q <= space_total_d;
      pulse_open_q  <= pulse_open_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // an open pulse means the pending space was already flushed
  a_open_no_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_open_q |-> (space_total_q == '0))
    else $error("space pending while pulse open");

  a_closed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pulse_open_q |-> (pulse_total_q == '0))
    else $error("pulse total left over after close");

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit) |=> out_valid_q)
    else $error("emitted run not registered");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && fire) |-> !emit)
    else $error("run emitted into stalled output");

endmodule
